[src/aps_pkg.sv]
// shared widths, codes, reset values and control types of the phase sequencer
package aps_pkg;

  localparam int FUNC_W     = 3;
  localparam int SECS_W     = 20;
  localparam int PHASE_W    = 3;
  localparam int CYC_W      = 2;
  localparam int TIME_W     = 16;
  localparam int ELAPSED_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // function codes
  localparam logic [FUNC_W-1:0] FN_CANCEL  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_STOP    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GO      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LIGHT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REGULAR = 3'd4;
  localparam logic [FUNC_W-1:0] FN_HEAVY   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_ADVANCE = 3'd6;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PAUSE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WASH  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RINSE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DRY   = 3'd4;

  // cycle codes
  localparam logic [CYC_W-1:0] CYC_LIGHT   = 2'd0;
  localparam logic [CYC_W-1:0] CYC_REGULAR = 2'd1;
  localparam logic [CYC_W-1:0] CYC_HEAVY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_WASH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGULAR_WASH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_WASH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RINSE_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_TIME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ELAPSED_LIM  = 3'd5;

  // configuration reset values
  localparam logic [TIME_W-1:0]    RST_LIGHT_WASH   = 16'd600;
  localparam logic [TIME_W-1:0]    RST_REGULAR_WASH = 16'd1200;
  localparam logic [TIME_W-1:0]    RST_HEAVY_WASH   = 16'd1800;
  localparam logic [TIME_W-1:0]    RST_RINSE_TIME   = 16'd600;
  localparam logic [TIME_W-1:0]    RST_DRY_TIME     = 16'd1200;
  localparam logic [ELAPSED_W-1:0] RST_ELAPSED_LIM  = 24'd999999;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // apply the function to the state
    logic step;   // one phase-spending step of an advance
    logic emit;   // load the result register
  } aps_cmd_t;

  typedef struct packed {
    logic spend_needed;  // advance on a running phase
    logic spend_last;    // this step finishes the advance
    logic out_free;      // result register can take a new result
  } aps_stat_t;

endpackage

[src/aps_in_if.sv]
// input channel: function code and advance seconds
interface aps_in_if;
  logic                         valid;
  logic                         ready;
  logic [aps_pkg::FUNC_W-1:0]   func;
  logic [aps_pkg::SECS_W-1:0]   advance_seconds;

  modport source (output valid, output func, output advance_seconds, input ready);
  modport sink   (input valid, input func, input advance_seconds, output ready);
endinterface

[src/aps_out_if.sv]
// result channel: phase, cycle, timer, elapsed count and flags
interface aps_out_if;
  logic                           valid;
  logic                           ready;
  logic [aps_pkg::PHASE_W-1:0]    phase;
  logic [aps_pkg::CYC_W-1:0]      selected_cycle;
  logic [aps_pkg::TIME_W-1:0]     seconds_left;
  logic [aps_pkg::ELAPSED_W-1:0]  elapsed_seconds;
  logic                           within_limit;
  logic                           select_rejected;

  modport source (output valid, output phase, output selected_cycle, output seconds_left,
                  output elapsed_seconds, output within_limit, output select_rejected,
                  input ready);
  modport sink   (input valid, input phase, input selected_cycle, input seconds_left,
                  input elapsed_seconds, input within_limit, input select_rejected,
                  output ready);
endinterface

[src/appliance_phase_sequencer.sv]
// top level of the wash-rinse-dry phase sequencer
//
// in_ch carries one button or time transaction (func, advance_seconds) and
// out_ch returns exactly one result transaction for each: phase, selected
// cycle, seconds left, elapsed seconds and the two flags, all taken after
// the transaction has been applied. cfg_we/cfg_idx/cfg_data write the phase
// times and the elapsed limit; write them only while no transaction is open.
// One transaction is worked at a time: it is captured, the function is
// applied, an advance on a running phase then takes phase-spending steps
// (one phase boundary per cycle), and last the result register is loaded.
// in_ch.ready returns in the cycle after the result is loaded. The result
// register holds while out_ch.ready is low; the next transaction is
// accepted and worked meanwhile and waits for the register to drain
// before it is loaded.
// Synchronous reset puts the block idle, regular cycle, timer and elapsed
// count zero, configuration at its defaults and out_ch.valid low.
module appliance_phase_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  aps_in_if.sink                          in_ch,
  aps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [aps_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [aps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  aps_pkg::aps_cmd_t  cmd;
  aps_pkg::aps_stat_t stat;

  aps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aps_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_ch.func),
    .in_secs      (in_ch.advance_seconds),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_phase    (out_ch.phase),
    .out_cycle    (out_ch.selected_cycle),
    .out_left     (out_ch.seconds_left),
    .out_elapsed  (out_ch.elapsed_seconds),
    .out_within   (out_ch.within_limit),
    .out_rejected (out_ch.select_rejected)
  );

  // one transaction at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("transaction accepted while another is open");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("result loaded but not shown");

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.phase != aps_pkg::PH_IDLE || out_ch.seconds_left == '0))
    else $error("idle result with time left");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.step, cmd.emit}))
    else $error("overlapping controller commands");

endmodule

[src/aps_ctrl.sv]
// controller state machine: accept, execute, spend steps, emit
module aps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aps_pkg::aps_stat_t  stat,
  output aps_pkg::aps_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SPEND = 4'b0100,
    ST_EMIT  = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.spend_needed ? ST_SPEND : ST_EMIT;
      end
      ST_SPEND: begin
        cmd.step = 1'b1;
        if (stat.spend_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the result register to drain
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/aps_dpath.sv]
// datapath: configuration, phase state, timer, elapsed counter and result register
module aps_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aps_pkg::aps_cmd_t                cmd,
  output aps_pkg::aps_stat_t               stat,
  input  logic [aps_pkg::FUNC_W-1:0]       in_func,
  input  logic [aps_pkg::SECS_W-1:0]       in_secs,
  input  logic                             cfg_we,
  input  logic [aps_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [aps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [aps_pkg::PHASE_W-1:0]      out_phase,
  output logic [aps_pkg::CYC_W-1:0]        out_cycle,
  output logic [aps_pkg::TIME_W-1:0]       out_left,
  output logic [aps_pkg::ELAPSED_W-1:0]    out_elapsed,
  output logic                             out_within,
  output logic                             out_rejected
);

  localparam int TW = aps_pkg::TIME_W;
  localparam int EW = aps_pkg::ELAPSED_W;
  localparam int SW = aps_pkg::SECS_W;

  // configuration
  logic [TW-1:0] light_r, regular_r, heavy_r, rinse_r, dry_r;
  logic [EW-1:0] limit_r;

  // sequencer state
  logic [aps_pkg::PHASE_W-1:0] phase_r, phase_nxt, resume_r, resume_nxt;
  logic [aps_pkg::CYC_W-1:0]   cycle_r, cycle_nxt;
  logic [TW-1:0]               timer_r, timer_nxt;
  logic [EW-1:0]               elapsed_r, elapsed_nxt;

  // transaction under work
  logic [aps_pkg::FUNC_W-1:0]  func_r, func_nxt;
  logic [SW-1:0]               secs_r, secs_nxt;
  logic [SW-1:0]               rest_r, rest_nxt;
  logic                        rej_r, rej_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [aps_pkg::PHASE_W-1:0] out_phase_r;
  logic [aps_pkg::CYC_W-1:0]   out_cycle_r;
  logic [TW-1:0]               out_left_r;
  logic [EW-1:0]               out_elapsed_r;
  logic                        out_within_r, out_rejected_r;

  logic                        running;
  logic [TW-1:0]               wash_time;
  logic                        rest_lt;
  logic [SW-1:0]               rest_sub;
  logic [aps_pkg::PHASE_W-1:0] adv_phase;
  logic [TW-1:0]               adv_time;
  logic [EW:0]                 elapsed_sum;
  logic [EW-1:0]               elapsed_sat;
  logic [aps_pkg::FUNC_W-1:0]  sel_off;

  assign running = (phase_r == aps_pkg::PH_WASH) || (phase_r == aps_pkg::PH_RINSE) ||
                   (phase_r == aps_pkg::PH_DRY);

  always_comb begin
    unique case (cycle_r)
      aps_pkg::CYC_LIGHT: wash_time = light_r;
      aps_pkg::CYC_HEAVY: wash_time = heavy_r;
      default:            wash_time = regular_r;
    endcase
  end

  // select codes map onto cycle codes in order
  assign sel_off = func_r - aps_pkg::FN_LIGHT;

  // one step of spending seconds against the phase timer
  assign rest_lt  = rest_r < {{(SW-TW){1'b0}}, timer_r};
  assign rest_sub = rest_r - {{(SW-TW){1'b0}}, timer_r};

  always_comb begin
    unique case (phase_r)
      aps_pkg::PH_WASH: begin
        adv_phase = aps_pkg::PH_RINSE;
        adv_time  = rinse_r;
      end
      aps_pkg::PH_RINSE: begin
        adv_phase = aps_pkg::PH_DRY;
        adv_time  = dry_r;
      end
      default: begin
        adv_phase = aps_pkg::PH_IDLE;
        adv_time  = '0;
      end
    endcase
  end

  assign elapsed_sum = {1'b0, elapsed_r} + {{(EW+1-SW){1'b0}}, secs_r};
  assign elapsed_sat = elapsed_sum[EW] ? aps_pkg::ELAPSED_MAX : elapsed_sum[EW-1:0];

  assign stat.spend_needed = (func_r == aps_pkg::FN_ADVANCE) && running;
  assign stat.spend_last   = rest_lt || (adv_phase == aps_pkg::PH_IDLE) || (rest_sub == '0);
  assign stat.out_free     = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt   = phase_r;
    resume_nxt  = resume_r;
    cycle_nxt   = cycle_r;
    timer_nxt   = timer_r;
    elapsed_nxt = elapsed_r;
    func_nxt    = func_r;
    secs_nxt    = secs_r;
    rest_nxt    = rest_r;
    rej_nxt     = rej_r;

    if (cmd.load) begin
      func_nxt = in_func;
      secs_nxt = in_secs;
      rest_nxt = in_secs;
      rej_nxt  = 1'b0;
    end

    if (cmd.exec) begin
      unique case (func_r)
        aps_pkg::FN_CANCEL: begin
          phase_nxt = aps_pkg::PH_IDLE;
          timer_nxt = '0;
        end
        aps_pkg::FN_STOP: begin
          if (running) begin
            resume_nxt = phase_r;
            phase_nxt  = aps_pkg::PH_PAUSE;
          end
        end
        aps_pkg::FN_GO: begin
          if (phase_r == aps_pkg::PH_IDLE) begin
            phase_nxt = aps_pkg::PH_WASH;
            timer_nxt = wash_time;
          end else if (phase_r == aps_pkg::PH_PAUSE) begin
            phase_nxt = resume_r;
          end
        end
        aps_pkg::FN_LIGHT, aps_pkg::FN_REGULAR, aps_pkg::FN_HEAVY: begin
          if (phase_r == aps_pkg::PH_IDLE) begin
            cycle_nxt = sel_off[aps_pkg::CYC_W-1:0];
          end else begin
            rej_nxt = 1'b1;
          end
        end
        aps_pkg::FN_ADVANCE: begin
          elapsed_nxt = elapsed_sat;
        end
        default: begin
        end
      endcase
    end

    if (cmd.step) begin
      if (rest_lt) begin
        timer_nxt = timer_r - rest_r[TW-1:0];
        rest_nxt  = '0;
      end else begin
        rest_nxt  = rest_sub;
        phase_nxt = adv_phase;
        timer_nxt = adv_time;
      end
    end
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r     <= aps_pkg::RST_LIGHT_WASH;
      regular_r   <= aps_pkg::RST_REGULAR_WASH;
      heavy_r     <= aps_pkg::RST_HEAVY_WASH;
      rinse_r     <= aps_pkg::RST_RINSE_TIME;
      dry_r       <= aps_pkg::RST_DRY_TIME;
      limit_r     <= aps_pkg::RST_ELAPSED_LIM;
      phase_r     <= aps_pkg::PH_IDLE;
      resume_r    <= aps_pkg::PH_IDLE;
      cycle_r     <= aps_pkg::CYC_REGULAR;
      timer_r     <= '0;
      elapsed_r   <= '0;
      func_r      <= aps_pkg::FN_CANCEL;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      resume_r    <= resume_nxt;
      cycle_r     <= cycle_nxt;
      timer_r     <= timer_nxt;
      elapsed_r   <= elapsed_nxt;
      func_r      <= func_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          aps_pkg::CFG_LIGHT_WASH:   light_r   <= cfg_data[TW-1:0];
          aps_pkg::CFG_REGULAR_WASH: regular_r <= cfg_data[TW-1:0];
          aps_pkg::CFG_HEAVY_WASH:   heavy_r   <= cfg_data[TW-1:0];
          aps_pkg::CFG_RINSE_TIME:   rinse_r   <= cfg_data[TW-1:0];
          aps_pkg::CFG_DRY_TIME:     dry_r     <= cfg_data[TW-1:0];
          aps_pkg::CFG_ELAPSED_LIM:  limit_r   <= cfg_data[EW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    secs_r <= secs_nxt;
    rest_r <= rest_nxt;
    if (cmd.emit) begin
      out_phase_r    <= phase_r;
      out_cycle_r    <= cycle_r;
      out_left_r     <= timer_r;
      out_elapsed_r  <= elapsed_r;
      out_within_r   <= elapsed_r <= limit_r;
      out_rejected_r <= rej_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_phase    = out_phase_r;
  assign out_cycle    = out_cycle_r;
  assign out_left     = out_left_r;
  assign out_elapsed  = out_elapsed_r;
  assign out_within   = out_within_r;
  assign out_rejected = out_rejected_r;

endmodule

[tb/tb_appliance_phase_sequencer.sv]
// testbench of the wash-rinse-dry phase sequencer: directed and random traffic against a predictor
`timescale 1ns / 100ps

module tb_appliance_phase_sequencer;

  localparam int FW = aps_pkg::FUNC_W;
  localparam int SW = aps_pkg::SECS_W;
  localparam int PW = aps_pkg::PHASE_W;
  localparam int CW = aps_pkg::CYC_W;
  localparam int TW = aps_pkg::TIME_W;
  localparam int EW = aps_pkg::ELAPSED_W;
  localparam int IW = aps_pkg::CFG_IDX_W;
  localparam int DW = aps_pkg::CFG_DATA_W;

  localparam logic [FW-1:0] FN_UNUSED    = 3'd7;
  localparam logic [IW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int            CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [PW-1:0] phase;
    logic [CW-1:0] selected_cycle;
    logic [TW-1:0] seconds_left;
    logic [EW-1:0] elapsed_seconds;
    logic          within_limit;
    logic          select_rejected;
  } status_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IW-1:0] cfg_idx;
  logic [DW-1:0] cfg_data;

  aps_in_if  in_ch ();
  aps_out_if out_ch ();

  appliance_phase_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predicted register settings
  logic [TW-1:0] light_secs   = aps_pkg::RST_LIGHT_WASH;
  logic [TW-1:0] regular_secs = aps_pkg::RST_REGULAR_WASH;
  logic [TW-1:0] heavy_secs   = aps_pkg::RST_HEAVY_WASH;
  logic [TW-1:0] rinse_secs   = aps_pkg::RST_RINSE_TIME;
  logic [TW-1:0] dry_secs     = aps_pkg::RST_DRY_TIME;
  logic [EW-1:0] elapsed_cap  = aps_pkg::RST_ELAPSED_LIM;

  // predicted sequencer state
  logic [PW-1:0] exp_phase   = aps_pkg::PH_IDLE;
  logic [PW-1:0] exp_resume  = aps_pkg::PH_IDLE;
  logic [CW-1:0] exp_cycle   = aps_pkg::CYC_REGULAR;
  logic [TW-1:0] exp_timer   = '0;
  logic [EW-1:0] exp_elapsed = '0;

  status_t pending_status [$];
  int      error_count = 0;
  int      items_sent  = 0;
  int      cycle_count = 0;
  int      sink_stall  = 0;
  bit      no_idle     = 1'b0;
  status_t want;
  status_t got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("appliance_phase_sequencer verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  function automatic logic [TW-1:0] wash_secs();
    case (exp_cycle)
      aps_pkg::CYC_LIGHT: return light_secs;
      aps_pkg::CYC_HEAVY: return heavy_secs;
      default:            return regular_secs;
    endcase
  endfunction

  function automatic void apply_register(input logic [IW-1:0] idx,
                                         input logic [DW-1:0] data);
    case (idx)
      aps_pkg::CFG_LIGHT_WASH:   light_secs   = data[TW-1:0];
      aps_pkg::CFG_REGULAR_WASH: regular_secs = data[TW-1:0];
      aps_pkg::CFG_HEAVY_WASH:   heavy_secs   = data[TW-1:0];
      aps_pkg::CFG_RINSE_TIME:   rinse_secs   = data[TW-1:0];
      aps_pkg::CFG_DRY_TIME:     dry_secs     = data[TW-1:0];
      aps_pkg::CFG_ELAPSED_LIM:  elapsed_cap  = data[EW-1:0];
      default: ;
    endcase
  endfunction

  function automatic status_t predict_status(input logic [FW-1:0] f,
                                             input logic [SW-1:0] s);
    status_t       res;
    logic          running;
    logic          rejected;
    logic [SW-1:0] rest;
    logic [EW:0]   total;
    running  = (exp_phase == aps_pkg::PH_WASH) || (exp_phase == aps_pkg::PH_RINSE) ||
               (exp_phase == aps_pkg::PH_DRY);
    rejected = 1'b0;
    case (f)
      aps_pkg::FN_CANCEL: begin
        if (exp_phase != aps_pkg::PH_IDLE) begin
          exp_phase = aps_pkg::PH_IDLE;
          exp_timer = '0;
        end
      end
      aps_pkg::FN_STOP: begin
        if (running) begin
          exp_resume = exp_phase;
          exp_phase  = aps_pkg::PH_PAUSE;
        end
      end
      aps_pkg::FN_GO: begin
        if (exp_phase == aps_pkg::PH_IDLE) begin
          exp_phase = aps_pkg::PH_WASH;
          exp_timer = wash_secs();
        end else if (exp_phase == aps_pkg::PH_PAUSE) begin
          exp_phase = exp_resume;
        end
      end
      aps_pkg::FN_LIGHT, aps_pkg::FN_REGULAR, aps_pkg::FN_HEAVY: begin
        if (exp_phase == aps_pkg::PH_IDLE) exp_cycle = CW'(f - aps_pkg::FN_LIGHT);
        else rejected = 1'b1;
      end
      aps_pkg::FN_ADVANCE: begin
        rest = s;
        // one phase boundary per pass; a zero timer still moves on once
        if (running) begin
          do begin
            if (rest < SW'(exp_timer)) begin
              exp_timer = exp_timer - TW'(rest);
              rest = '0;
            end else begin
              rest = rest - SW'(exp_timer);
              case (exp_phase)
                aps_pkg::PH_WASH: begin
                  exp_phase = aps_pkg::PH_RINSE;
                  exp_timer = rinse_secs;
                end
                aps_pkg::PH_RINSE: begin
                  exp_phase = aps_pkg::PH_DRY;
                  exp_timer = dry_secs;
                end
                default: begin
                  exp_phase = aps_pkg::PH_IDLE;
                  exp_timer = '0;
                end
              endcase
            end
          end while (exp_phase != aps_pkg::PH_IDLE && rest != '0);
        end
        total = {1'b0, exp_elapsed} + {{(EW+1-SW){1'b0}}, s};
        exp_elapsed = (total > {1'b0, aps_pkg::ELAPSED_MAX}) ? aps_pkg::ELAPSED_MAX :
                      total[EW-1:0];
      end
      default: ;
    endcase
    res.phase           = exp_phase;
    res.selected_cycle  = exp_cycle;
    res.seconds_left    = exp_timer;
    res.elapsed_seconds = exp_elapsed;
    res.within_limit    = (exp_elapsed <= elapsed_cap);
    res.select_rejected = rejected;
    return res;
  endfunction

  function automatic void check_status(input status_t exp_s, input status_t act);
    if (act.phase !== exp_s.phase) begin
      $error("phase: expected %0d, actual %0d", exp_s.phase, act.phase);
      error_count++;
    end
    if (act.selected_cycle !== exp_s.selected_cycle) begin
      $error("selected_cycle: expected %0d, actual %0d", exp_s.selected_cycle,
             act.selected_cycle);
      error_count++;
    end
    if (act.seconds_left !== exp_s.seconds_left) begin
      $error("seconds_left: expected %0d, actual %0d", exp_s.seconds_left, act.seconds_left);
      error_count++;
    end
    if (act.elapsed_seconds !== exp_s.elapsed_seconds) begin
      $error("elapsed_seconds: expected %0d, actual %0d", exp_s.elapsed_seconds,
             act.elapsed_seconds);
      error_count++;
    end
    if (act.within_limit !== exp_s.within_limit) begin
      $error("within_limit: expected %0d, actual %0d", exp_s.within_limit, act.within_limit);
      error_count++;
    end
    if (act.select_rejected !== exp_s.select_rejected) begin
      $error("select_rejected: expected %0d, actual %0d", exp_s.select_rejected,
             act.select_rejected);
      error_count++;
    end
  endfunction

  // result side: check each accepted transaction, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.phase           = out_ch.phase;
      got.selected_cycle  = out_ch.selected_cycle;
      got.seconds_left    = out_ch.seconds_left;
      got.elapsed_seconds = out_ch.elapsed_seconds;
      got.within_limit    = out_ch.within_limit;
      got.select_rejected = out_ch.select_rejected;
      if (pending_status.size() == 0) begin
        $error("result transaction with nothing pending");
        error_count++;
      end else begin
        want = pending_status.pop_front();
        check_status(want, got);
      end
    end
    if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  // valid stays high after a transaction; a gap before the next send or an idle wait lowers it
  task automatic send_item(input logic [FW-1:0] f, input logic [SW-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= f;
    in_ch.advance_seconds <= s;
    do @(posedge clk); while (!in_ch.ready);
    pending_status.push_back(predict_status(f, s));
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [TW-1:0] light, input logic [TW-1:0] regular,
                               input logic [TW-1:0] heavy, input logic [TW-1:0] rinse,
                               input logic [TW-1:0] dry, input logic [EW-1:0] limit);
    logic [DW-1:0] word [8];
    logic [IW-1:0] idx_list [8];
    drain_results();
    idx_list = '{aps_pkg::CFG_LIGHT_WASH, aps_pkg::CFG_REGULAR_WASH,
                 aps_pkg::CFG_HEAVY_WASH, aps_pkg::CFG_RINSE_TIME,
                 aps_pkg::CFG_DRY_TIME, aps_pkg::CFG_ELAPSED_LIM,
                 CFG_SPARE_LO, CFG_SPARE_HI};
    // junk in the upper byte of the 16-bit registers must be dropped
    word[0] = {8'($urandom()), light};
    word[1] = {8'($urandom()), regular};
    word[2] = {8'($urandom()), heavy};
    word[3] = {8'($urandom()), rinse};
    word[4] = {8'($urandom()), dry};
    word[5] = limit;
    word[6] = DW'($urandom());
    word[7] = DW'($urandom());
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_list[i];
      cfg_data <= word[i];
      @(posedge clk);
      apply_register(idx_list[i], word[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SW-1:0] pick_seconds();
    int r;
    logic [SW-1:0] t;
    t = SW'(exp_timer);
    r = $urandom_range(0, 39);
    if (r < 4) return '0;
    if (r < 10) return t;
    if (r < 14) return (t == '0) ? '0 : t - SW'(1);
    if (r < 18) return t + SW'(1);
    if (r < 21) return t + SW'(rinse_secs) + SW'(dry_secs);
    if (r < 34) return SW'($urandom_range(0, 2047));
    if (r < 38) return SW'($urandom_range(0, 15));
    return SW'($urandom());
  endfunction

  function automatic logic [SW-1:0] junk_secs();
    return SW'($urandom());
  endfunction

  // select, go, then a run of advances with pauses and stray buttons mixed in
  task automatic run_wash_program();
    int steps;
    int choice;
    if (exp_phase != aps_pkg::PH_IDLE) send_item(aps_pkg::FN_CANCEL, junk_secs());
    send_item(aps_pkg::FN_LIGHT + FW'($urandom_range(0, 2)), junk_secs());
    send_item(aps_pkg::FN_GO, junk_secs());
    steps = $urandom_range(2, 10);
    repeat (steps) begin
      choice = $urandom_range(0, 19);
      if (choice < 13) begin
        send_item(aps_pkg::FN_ADVANCE, pick_seconds());
      end else if (choice < 15) begin
        send_item(aps_pkg::FN_STOP, junk_secs());
        if ($urandom_range(0, 1)) send_item(aps_pkg::FN_ADVANCE, pick_seconds());
        send_item(aps_pkg::FN_GO, junk_secs());
      end else if (choice == 15) begin
        send_item(aps_pkg::FN_LIGHT + FW'($urandom_range(0, 2)), junk_secs());
      end else if (choice == 16) begin
        send_item(aps_pkg::FN_GO, junk_secs());
      end else if (choice == 17) begin
        send_item(aps_pkg::FN_CANCEL, junk_secs());
      end else begin
        send_item(FW'($urandom_range(0, 7)), junk_secs());
      end
    end
  endtask

  task automatic random_traffic(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 8) begin
        run_wash_program();
      end else begin
        repeat ($urandom_range(1, 4)) send_item(FW'($urandom_range(0, 7)), junk_secs());
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_idle_behavior();
    send_item(FN_UNUSED, '1);
    send_item(aps_pkg::FN_ADVANCE, '0);
    send_item(aps_pkg::FN_CANCEL, '0);
    send_item(aps_pkg::FN_STOP, '0);
  endtask

  task automatic test_cycle_select();
    send_item(aps_pkg::FN_LIGHT, '0);
    send_item(aps_pkg::FN_HEAVY, '0);
    send_item(aps_pkg::FN_REGULAR, '0);
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_LIGHT, '0);
    send_item(aps_pkg::FN_CANCEL, '0);
  endtask

  task automatic test_pause_resume();
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_STOP, '0);
    send_item(aps_pkg::FN_STOP, '0);
    send_item(aps_pkg::FN_HEAVY, '0);
    send_item(aps_pkg::FN_ADVANCE, 20'd100);
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_CANCEL, '0);
  endtask

  task automatic test_phase_crossing();
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_ADVANCE, 20'd1199);
    send_item(aps_pkg::FN_ADVANCE, 20'd1);
    send_item(aps_pkg::FN_ADVANCE, '1);
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_ADVANCE, 20'd3000);
  endtask

  task automatic test_zero_phase_times();
    load_settings('0, '0, '0, '0, '0, '0);
    send_item(aps_pkg::FN_GO, '0);
    send_item(aps_pkg::FN_ADVANCE, '0);
    send_item(aps_pkg::FN_ADVANCE, '0);
    send_item(aps_pkg::FN_ADVANCE, 20'd5);
  endtask

  task automatic test_random_programs();
    load_settings(TW'($urandom_range(0, 40)), TW'($urandom_range(0, 40)),
                  TW'($urandom_range(0, 40)), TW'($urandom_range(0, 40)),
                  TW'($urandom_range(0, 40)), EW'($urandom_range(0, 50000)));
    random_traffic(260);
    load_settings('1, '1, '1, '1, '1, aps_pkg::ELAPSED_MAX);
    random_traffic(260);
    load_settings(TW'($urandom()), TW'($urandom()), TW'($urandom()),
                  TW'($urandom()), TW'($urandom()), EW'($urandom()));
    random_traffic(260);
    load_settings($urandom_range(0, 1) ? TW'(0) : TW'($urandom_range(1, 20)),
                  $urandom_range(0, 1) ? TW'(0) : TW'($urandom_range(1, 20)),
                  $urandom_range(0, 1) ? TW'(0) : TW'($urandom_range(1, 20)),
                  $urandom_range(0, 1) ? TW'(0) : TW'($urandom_range(1, 20)),
                  $urandom_range(0, 1) ? TW'(0) : TW'($urandom_range(1, 20)), '0);
    random_traffic(260);
    load_settings(aps_pkg::RST_LIGHT_WASH, aps_pkg::RST_REGULAR_WASH,
                  aps_pkg::RST_HEAVY_WASH, aps_pkg::RST_RINSE_TIME,
                  aps_pkg::RST_DRY_TIME, aps_pkg::RST_ELAPSED_LIM);
    random_traffic(260);
  endtask

  task automatic test_elapsed_saturation();
    load_settings(aps_pkg::RST_LIGHT_WASH, aps_pkg::RST_REGULAR_WASH,
                  aps_pkg::RST_HEAVY_WASH, aps_pkg::RST_RINSE_TIME,
                  aps_pkg::RST_DRY_TIME, aps_pkg::ELAPSED_MAX - EW'(1));
    while (exp_elapsed != aps_pkg::ELAPSED_MAX) send_item(aps_pkg::FN_ADVANCE, '1);
    send_item(aps_pkg::FN_ADVANCE, '1);
    load_settings(aps_pkg::RST_LIGHT_WASH, aps_pkg::RST_REGULAR_WASH,
                  aps_pkg::RST_HEAVY_WASH, aps_pkg::RST_RINSE_TIME,
                  aps_pkg::RST_DRY_TIME, aps_pkg::ELAPSED_MAX);
    send_item(aps_pkg::FN_ADVANCE, '0);
    send_item(aps_pkg::FN_LIGHT, '0);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= aps_pkg::FN_CANCEL;
    in_ch.advance_seconds <= '0;
    cfg_we                <= 1'b0;
    cfg_idx               <= aps_pkg::CFG_LIGHT_WASH;
    cfg_data              <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_behavior();
    test_cycle_select();
    test_pause_resume();
    test_phase_crossing();
    test_zero_phase_times();
    test_random_programs();
    test_elapsed_saturation();

    drain_results();
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("appliance_phase_sequencer verification clean");
    end else begin
      $display("appliance_phase_sequencer verification failed");
    end
    $finish;
  end

endmodule

[appliance_phase_sequencer.f]
src/aps_pkg.sv
src/aps_in_if.sv
src/aps_out_if.sv
src/aps_ctrl.sv
src/aps_dpath.sv
src/appliance_phase_sequencer.sv
tb/tb_appliance_phase_sequencer.sv
